/* rtl/rqq_pkg.sv */
// Shared types and constants for the priority bitmap ready queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rqq_pkg;

  // Field widths of the request and result channels
  localparam int THREAD_W = 6;
  localparam int LEVEL_W  = 5;

  // Default sizes of the stores
  localparam int RQQ_NUM_LEVELS  = 32;
  localparam int RQQ_NUM_THREADS = 64;

  // Entries in the queue between front and back end
  localparam int RQQ_QUEUE_DEPTH = 2;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_GET = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_ADDED  = 2'd0,
    STAT_TAKEN  = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_REJECT = 2'd3
  } status_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } rqq_state_t;

  // Classified request as it travels from front to back end
  typedef struct packed {
    req_type_t             req_type;
    logic [THREAD_W-1:0]   thread_id;
    logic [LEVEL_W-1:0]    priority_req;
    logic                  range_ok;
  } rqq_item_t;

endpackage

`default_nettype wire

/* rtl/rqq_channels.sv */
// Valid/ready channel interfaces for requests and results of the ready queue.
// Depends on rqq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rqq_req_if import rqq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [THREAD_W-1:0] thread_id;
  logic [LEVEL_W-1:0]  priority_req;

  modport source (output valid, req_type, thread_id, priority_req, input ready);
  modport sink   (input valid, req_type, thread_id, priority_req, output ready);
endinterface

interface rqq_res_if import rqq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [THREAD_W-1:0] next_thread;
  logic [LEVEL_W-1:0]  next_priority;

  modport source (output valid, status, next_thread, next_priority, input ready);
  modport sink   (input valid, status, next_thread, next_priority, output ready);
endinterface

`default_nettype wire

/* rtl/priority_bitmap_ready_queue.sv */
// Top level of the priority bitmap ready queue: front end, request queue,
// back end. Depends on rqq_pkg, rqq_channels, rqq_front, rqq_fifo, rqq_back.
`timescale 1ns / 1ps
`default_nettype none

// Multilevel ready queue: one FIFO of threads per priority level, kept as
// linked lists in head, tail and link memories, with a bitmap of non-empty
// levels. Each request gives exactly one result, in request order. The front
// end takes a request whenever its two-entry queue has room, so requests can
// be posted while a result waits. The back end serves one request at a time:
// an add or an empty get does a memory read, then the update; a get that leaves
// its level non-empty adds a step, because the new head comes from a second
// registered read of the link memory. Unwritten memory entries may be read, but
// their values are never used; of the stores, only the bitmap and queued flags are reset.

module priority_bitmap_ready_queue import rqq_pkg::*; #(
  parameter int NUM_LEVELS  = RQQ_NUM_LEVELS,
  parameter int NUM_THREADS = RQQ_NUM_THREADS
) (
  input  logic       clk,
  input  logic       rst,
  rqq_req_if.sink    request,
  rqq_res_if.source  result
);

  logic       push_valid;
  logic       push_ready;
  rqq_item_t  push_item;
  logic       pop_valid;
  logic       pop_ready;
  rqq_item_t  pop_item;

  rqq_front #(
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_THREADS (NUM_THREADS)
  ) u_front (
    .request    (request),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  rqq_fifo #(
    .DEPTH (RQQ_QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  rqq_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .NUM_THREADS (NUM_THREADS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item       (pop_item),
    .item_ready (pop_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

/* rtl/rqq_front.sv */
// Front end: accepts requests and classifies them (type, range check).
// Depends on rqq_pkg and rqq_req_if.
`timescale 1ns / 1ps
`default_nettype none

module rqq_front import rqq_pkg::*; #(
  parameter int NUM_LEVELS  = RQQ_NUM_LEVELS,
  parameter int NUM_THREADS = RQQ_NUM_THREADS
) (
  rqq_req_if.sink    request,
  output logic       push_valid,
  output rqq_item_t  push_item,
  input  logic       push_ready
);

  logic thread_ok;
  logic level_ok;

  // An add names a thread and a level that must exist in the stores
  assign thread_ok = 32'(request.thread_id) < 32'(NUM_THREADS);
  assign level_ok  = 32'(request.priority_req) < 32'(NUM_LEVELS);

  assign request.ready = push_ready;
  assign push_valid    = request.valid;

  always_comb begin
    push_item.req_type     = req_type_t'(request.req_type);
    push_item.thread_id    = request.thread_id;
    push_item.priority_req = request.priority_req;
    push_item.range_ok     = (request.req_type == REQ_GET) || (thread_ok && level_ok);
  end

endmodule

`default_nettype wire

/* rtl/rqq_fifo.sv */
// Short queue of classified requests between front and back end.
// Depends on rqq_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module rqq_fifo import rqq_pkg::*; #(
  parameter int DEPTH = RQQ_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  rqq_item_t  push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output rqq_item_t  pop_item,
  input  logic       pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rqq_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rqq_back.sv */
// Back end: carries out add and get requests on the level bitmap and the
// head, tail and link memories, and holds the result register.
// Depends on rqq_pkg and rqq_res_if.
`timescale 1ns / 1ps
`default_nettype none

module rqq_back import rqq_pkg::*; #(
  parameter int NUM_LEVELS  = RQQ_NUM_LEVELS,
  parameter int NUM_THREADS = RQQ_NUM_THREADS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  rqq_item_t  item,
  output logic       item_ready,
  rqq_res_if.source  result
);

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int THR_W = $clog2(NUM_THREADS);

  // Memories: per-level head and tail, per-thread successor
  logic [THR_W-1:0] level_head [NUM_LEVELS];
  logic [THR_W-1:0] level_tail [NUM_LEVELS];
  logic [THR_W-1:0] link_next  [NUM_THREADS];

  logic [NUM_LEVELS-1:0]  ready_levels;
  logic [NUM_THREADS-1:0] is_queued;

  rqq_state_t        state;
  rqq_state_t        state_next;

  // Request under way
  req_type_t         op_req;
  logic [THR_W-1:0]  op_tid;
  logic [LVL_W-1:0]  op_lvl;
  logic              op_range_ok;
  logic [LVL_W-1:0]  get_lvl;
  logic              get_hit;

  // Registered memory read data
  logic [THR_W-1:0]  head_rd;
  logic [THR_W-1:0]  tail_rd;
  logic [THR_W-1:0]  link_rd;

  logic [LVL_W-1:0]  ffs_lvl;
  logic [LVL_W-1:0]  rd_lvl;
  logic              start;
  logic              upd_add;
  logic              upd_take;
  logic              take_last;
  logic              add_reject;
  logic              res_load;
  status_t           res_status;

  logic              res_valid;
  logic [1:0]        res_status_q;
  logic [THREAD_W-1:0] res_thread;
  logic [LEVEL_W-1:0]  res_level;

  // Lowest set bit of the level bitmap
  function automatic logic [LVL_W-1:0] first_set(input logic [NUM_LEVELS-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  assign ffs_lvl = first_set(ready_levels);
  assign rd_lvl  = (item.req_type == REQ_GET) ? ffs_lvl : LVL_W'(item.priority_req);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: begin
        if (upd_take && !take_last) state_next = ST_POP;
        else                        state_next = ST_IDLE;
      end
      ST_POP:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_ready = 1'b0;
    res_load   = 1'b0;
    upd_add    = 1'b0;
    upd_take   = 1'b0;
    add_reject = !op_range_ok || is_queued[op_tid];
    take_last  = head_rd == tail_rd;
    res_status = STAT_EMPTY;
    case (state)
      ST_IDLE: item_ready = !res_valid || result.ready;
      ST_EXEC: begin
        res_load = 1'b1;
        if (op_req == REQ_ADD) begin
          upd_add    = !add_reject;
          res_status = add_reject ? STAT_REJECT : STAT_ADDED;
        end else begin
          upd_take   = get_hit;
          res_status = get_hit ? STAT_TAKEN : STAT_EMPTY;
        end
      end
      default: ;
    endcase
  end

  assign start = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request and the level a get will serve
  always_ff @(posedge clk) begin
    if (start) begin
      op_req      <= item.req_type;
      op_tid      <= THR_W'(item.thread_id);
      op_lvl      <= LVL_W'(item.priority_req);
      op_range_ok <= item.range_ok;
      get_lvl     <= ffs_lvl;
      get_hit     <= |ready_levels;
    end
  end

  // Memory reads, registered
  always_ff @(posedge clk) begin
    head_rd <= level_head[rd_lvl];
    tail_rd <= level_tail[rd_lvl];
    link_rd <= link_next[head_rd];
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (upd_add) begin
      level_tail[op_lvl] <= op_tid;
      if (ready_levels[op_lvl]) begin
        link_next[tail_rd] <= op_tid;
      end else begin
        level_head[op_lvl] <= op_tid;
      end
    end else if (state == ST_POP) begin
      level_head[get_lvl] <= link_rd;
    end
  end

  // Level bitmap and queued flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_levels <= '0;
      is_queued    <= '0;
    end else begin
      if (upd_add) begin
        ready_levels[op_lvl] <= 1'b1;
        is_queued[op_tid]    <= 1'b1;
      end
      if (upd_take) begin
        is_queued[head_rd] <= 1'b0;
        if (take_last) ready_levels[get_lvl] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status_q <= res_status;
      res_thread   <= upd_take ? THREAD_W'(head_rd) : '0;
      res_level    <= upd_take ? LEVEL_W'(get_lvl) : '0;
    end
  end

  assign result.valid         = res_valid;
  assign result.status        = res_status_q;
  assign result.next_thread   = res_thread;
  assign result.next_priority = res_level;

endmodule

`default_nettype wire
